### rtl/rpn_pkg.sv
// shared types and codes for the rpn stack calculator
package rpn_pkg;

    localparam int DATA_W = 32;

    // command codes carried in tuser of the input stream
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_APPLY = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_FEW     = 3'd3;
    localparam logic [2:0] ST_DIVZERO = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    // ascii operator characters
    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;

    localparam logic [DATA_W-1:0] VALUE_EMPTY = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_DIV,
        S_OUT
    } state_t;

endpackage

### rtl/rpn_div.sv
// radix-2 restoring signed divider, truncating toward zero, one bit per cycle
module rpn_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import rpn_pkg::*;

    localparam int STEPS = DATA_W;
    localparam int SW    = $clog2(STEPS);
    localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [SW-1:0]       step_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   den_reg;
    logic                neg_reg;

    logic [DATA_W:0]     trial;
    logic                fits;
    logic [DATA_W-1:0]   rem_next;
    logic [DATA_W-1:0]   quo_next;
    logic [DATA_W-1:0]   lhs_mag;
    logic [DATA_W-1:0]   rhs_mag;

    assign lhs_mag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign rhs_mag = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;

    // shift in the next dividend bit and try the subtract
    assign trial    = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, den_reg};
    assign fits     = ~trial[DATA_W];
    assign rem_next = fits ? trial[DATA_W-1:0] : {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
    assign quo_next = {quo_reg[DATA_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= lhs_mag;
            den_reg <= rhs_mag;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

### rtl/rpn_stack_calculator_top.sv
// rpn stack calculator: stack in a synchronous ram, sequencer and divider
// from accept to m_axis_tvalid: push, clear and rejected commands go from S_IDLE to S_OUT,
// pop and peek pass S_RD1, + - * pass S_RD1 and S_RD2, / adds S_DIV (32-step radix-2 divider loop)
// throughput: one item at a time, the next is taken once the result is registered
// stack ram reads are registered; apply reads top then second entry on one port
// reset (async, active low) empties the stack; ram contents are not cleared
module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // push_value[31:0], operator_char[39:32]
    input  logic [2:0]  s_axis_tuser,  // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // result_value[31:0], stack_depth[38:32], zero[39]
    output logic [2:0]  m_axis_tuser   // status[2:0]
);
    import rpn_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    state_t state_reg, state_next;

    logic [CW-1:0]     count_reg, count_next;
    logic [2:0]        op_reg, op_next;
    logic [7:0]        ch_reg, ch_next;
    logic [DATA_W-1:0] rhs_reg, rhs_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [2:0]        st_reg, st_next;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_res_reg;
    logic [2:0]        m_st_reg;
    logic [6:0]        m_depth_reg;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    logic              accept;
    logic              out_load;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] in_value;
    logic [7:0]        in_char;
    logic [CW+6:0]     depth_ext;

    assign in_value = s_axis_tdata[31:0];
    assign in_char  = s_axis_tdata[39:32];
    assign lhs      = rd_data_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_load      = (state_reg == S_OUT) & (~m_valid_reg | m_axis_tready);

    // stack ram, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lhs),
        .divisor  (rhs_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_OUT;
                    if ((s_axis_tuser == OP_POP || s_axis_tuser == OP_PEEK)
                        && count_reg != '0)
                    begin
                        state_next = S_RD1;
                    end
                    if (s_axis_tuser == OP_APPLY && count_reg >= TWO_C)
                    begin
                        state_next = S_RD1;
                    end
                end
            end
            S_RD1:
            begin
                state_next = (op_reg == OP_APPLY) ? S_RD2 : S_OUT;
            end
            S_RD2:
            begin
                state_next = (ch_reg == CH_DIV && rhs_reg != '0) ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and ram controls
    always_comb
    begin
        count_next = count_reg;
        op_next    = op_reg;
        ch_next    = ch_reg;
        rhs_next   = rhs_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        mem_we     = 1'b0;
        mem_waddr  = AW'(count_reg - TWO_C);
        mem_wdata  = res_reg;
        rd_addr    = AW'(count_reg - 1'b1);
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = s_axis_tuser;
                    ch_next  = in_char;
                    res_next = '0;
                    st_next  = ST_OK;
                    unique case (s_axis_tuser)
                        OP_PUSH:
                        begin
                            res_next = in_value;
                            if (count_reg < DEPTH_C)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = in_value;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                st_next = ST_FULL;
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next = VALUE_EMPTY;
                                st_next  = ST_EMPTY;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPLY:
                        begin
                            if (count_reg < TWO_C)
                            begin
                                st_next = ST_FEW;
                            end
                        end
                        default:
                        begin
                            st_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_RD1:
            begin
                if (op_reg == OP_APPLY)
                begin
                    rhs_next = rd_data_reg;
                    rd_addr  = AW'(count_reg - TWO_C);
                end
                else
                begin
                    res_next = rd_data_reg;
                    if (op_reg == OP_POP)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            S_RD2:
            begin
                unique case (ch_reg)
                    CH_ADD:
                    begin
                        res_next = lhs + rhs_reg;
                    end
                    CH_SUB:
                    begin
                        res_next = lhs - rhs_reg;
                    end
                    CH_MUL:
                    begin
                        res_next = lhs * rhs_reg;
                    end
                    CH_DIV:
                    begin
                        if (rhs_reg == '0)
                        begin
                            st_next = ST_DIVZERO;
                        end
                        else
                        begin
                            div_start = 1'b1;
                        end
                    end
                    default:
                    begin
                        st_next = ST_INVALID;
                    end
                endcase
                // operands are replaced by the result except on a kept case
                if (ch_reg == CH_ADD || ch_reg == CH_SUB || ch_reg == CH_MUL)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = res_next;
                    count_next = count_reg - 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quot;
                    mem_we     = 1'b1;
                    mem_wdata  = div_quot;
                    count_next = count_reg - 1'b1;
                end
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign depth_ext = {7'b0, count_reg};

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        ch_reg  <= ch_next;
        rhs_reg <= rhs_next;
        res_reg <= res_next;
        st_reg  <= st_next;
        if (out_load)
        begin
            m_res_reg   <= res_reg;
            m_st_reg    <= st_reg;
            m_depth_reg <= depth_ext[6:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_depth_reg, m_res_reg};
    assign m_axis_tuser  = m_st_reg;

endmodule

### rtl/rpn_checker.sv
// port-level checks for the rpn stack calculator, bound to the top level
module rpn_checker #(
    parameter int STACK_DEPTH = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import rpn_pkg::*;

    localparam logic [6:0] DEPTH_LOW = 7'(STACK_DEPTH);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a dropped push only happens on a full stack
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FULL |-> m_axis_tdata[38:32] == DEPTH_LOW)
        else $error("full drop with stack not full");

    // empty pop or peek gives all ones and an empty stack
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY |->
            m_axis_tdata[31:0] == VALUE_EMPTY && m_axis_tdata[38:32] == 7'd0)
        else $error("empty status with wrong value or depth");

    // too few operands leaves fewer than two entries and a zero value
    a_few: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FEW |->
            m_axis_tdata[38:32] < 7'd2 && m_axis_tdata[31:0] == '0)
        else $error("too few operands with wrong depth or value");

endmodule

bind rpn_stack_calculator_top rpn_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rpn_checker (.*);
